/* hdl/lts_pkg.sv */
// Shared types, token codes and helper functions for the token scanner.
package lts_pkg;

	localparam int OFFSET_BITS       = 16;
	localparam int KEYWORD_MAX_CHARS = 6;
	localparam int KW_BITS           = 8 * KEYWORD_MAX_CHARS;
	localparam int KIND_BITS         = 6;
	localparam int KW_COUNT          = 16;
	localparam int FIFO_DEPTH        = 4;
	localparam int FIFO_IDX_BITS     = $clog2(FIFO_DEPTH);

	// token kinds
	localparam logic [KIND_BITS-1:0] K_LEFT_PAREN    = 6'd0;
	localparam logic [KIND_BITS-1:0] K_RIGHT_PAREN   = 6'd1;
	localparam logic [KIND_BITS-1:0] K_LEFT_BRACE    = 6'd2;
	localparam logic [KIND_BITS-1:0] K_RIGHT_BRACE   = 6'd3;
	localparam logic [KIND_BITS-1:0] K_STAR          = 6'd4;
	localparam logic [KIND_BITS-1:0] K_DOT           = 6'd5;
	localparam logic [KIND_BITS-1:0] K_COMMA         = 6'd6;
	localparam logic [KIND_BITS-1:0] K_SEMICOLON     = 6'd7;
	localparam logic [KIND_BITS-1:0] K_EQUAL         = 6'd8;
	localparam logic [KIND_BITS-1:0] K_BANG          = 6'd10;
	localparam logic [KIND_BITS-1:0] K_GREATER       = 6'd12;
	localparam logic [KIND_BITS-1:0] K_LESS          = 6'd14;
	localparam logic [KIND_BITS-1:0] K_PLUS          = 6'd16;
	localparam logic [KIND_BITS-1:0] K_MINUS         = 6'd17;
	localparam logic [KIND_BITS-1:0] K_SLASH         = 6'd18;
	localparam logic [KIND_BITS-1:0] K_STRING        = 6'd19;
	localparam logic [KIND_BITS-1:0] K_STRING_ERROR  = 6'd20;
	localparam logic [KIND_BITS-1:0] K_NUMBER        = 6'd21;
	localparam logic [KIND_BITS-1:0] K_NUMBER_ERROR  = 6'd22;
	localparam logic [KIND_BITS-1:0] K_IDENTIFIER    = 6'd23;
	localparam logic [KIND_BITS-1:0] K_NEWLINE       = 6'd24;
	localparam logic [KIND_BITS-1:0] K_COMMENT       = 6'd25;
	localparam logic [KIND_BITS-1:0] K_WHITESPACE    = 6'd26;
	localparam logic [KIND_BITS-1:0] K_KEYWORD0      = 6'd27;
	localparam logic [KIND_BITS-1:0] K_UNKNOWN       = 6'd43;

	// pending operator codes
	localparam logic [2:0] OP_EQUAL   = 3'd0;
	localparam logic [2:0] OP_BANG    = 3'd1;
	localparam logic [2:0] OP_GREATER = 3'd2;
	localparam logic [2:0] OP_LESS    = 3'd3;
	localparam logic [2:0] OP_SLASH   = 3'd4;

	// what a byte does when it starts a token
	localparam logic [2:0] ACT_EMIT   = 3'd0;
	localparam logic [2:0] ACT_OPER   = 3'd1;
	localparam logic [2:0] ACT_STRING = 3'd2;
	localparam logic [2:0] ACT_NUMBER = 3'd3;
	localparam logic [2:0] ACT_WORD   = 3'd4;

	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_DOT     = 8'h2E;

	localparam logic [KW_BITS-1:0] KW_WORDS [KW_COUNT] = '{
		KW_BITS'("and"),   KW_BITS'("class"),  KW_BITS'("else"),  KW_BITS'("false"),
		KW_BITS'("for"),   KW_BITS'("fun"),    KW_BITS'("if"),    KW_BITS'("nil"),
		KW_BITS'("or"),    KW_BITS'("print"),  KW_BITS'("return"), KW_BITS'("super"),
		KW_BITS'("this"),  KW_BITS'("true"),   KW_BITS'("var"),   KW_BITS'("while")
	};

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} byte_beat_t;

	typedef struct packed {
		logic [KIND_BITS-1:0]   token_kind;
		logic [OFFSET_BITS-1:0] token_start;
		logic [OFFSET_BITS-1:0] token_length;
		logic                   last_of_run;
	} token_t;

	typedef struct packed {
		logic [2:0]           act;
		logic [2:0]           op;
		logic [KIND_BITS-1:0] kind;
		logic                 is_digit;
		logic                 is_word;
	} byte_class_t;

	typedef struct packed {
		logic [7:0]             text_byte;
		logic                   end_of_text;
		logic [OFFSET_BITS-1:0] pos;
		byte_class_t            cls;
	} entry_t;

	// one-byte operator kind; for = ! > < the two-byte form with = is one above
	function automatic logic [KIND_BITS-1:0] op_kind(input logic [2:0] op);
		logic [KIND_BITS-1:0] k;
		case (op)
			OP_EQUAL:   k = K_EQUAL;
			OP_BANG:    k = K_BANG;
			OP_GREATER: k = K_GREATER;
			OP_LESS:    k = K_LESS;
			default:    k = K_SLASH;
		endcase
		return k;
	endfunction

	function automatic logic [KIND_BITS-1:0] word_kind(input logic [KW_BITS-1:0] prefix,
		input logic too_long);
		logic [KIND_BITS-1:0] k;
		k = K_IDENTIFIER;
		if (!too_long) begin
			for (int i = 0; i < KW_COUNT; i++) begin
				if (prefix == KW_WORDS[i])
					k = K_KEYWORD0 + KIND_BITS'(i);
			end
		end
		return k;
	endfunction

	// p - st (+1), saturating at the offset range
	function automatic logic [OFFSET_BITS-1:0] tok_len(input logic [OFFSET_BITS-1:0] p,
		input logic [OFFSET_BITS-1:0] st, input logic plus_one);
		logic [OFFSET_BITS:0] s;
		s = {1'b0, p} - {1'b0, st} + {{OFFSET_BITS{1'b0}}, plus_one};
		return s[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : s[OFFSET_BITS-1:0];
	endfunction

endpackage

/* hdl/lox_token_scanner.sv */
// A queued byte's tokens are registered in the output stage when the back end takes it.
// Throughput: one byte per cycle without output stalls; a two-token byte holds the back
// end until its second token moves out, and the four-entry queue absorbs the difference.
// Under an output stall the queue fills to four bytes, then the input stalls.
// Reset clears the scanner state, the offset counter, the queue and the output.
module lox_token_scanner import lts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  byte_beat_t byte_data,
	output logic       token_valid,
	input  logic       token_stall,
	output token_t     token_data
);

	logic   push;
	logic   pop;
	logic   full;
	logic   not_empty;
	entry_t wr_entry;
	entry_t head;

	assign byte_stall = full;

	lts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_data  (byte_data),
		.full       (full),
		.push       (push),
		.entry      (wr_entry)
	);

	lts_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (wr_entry),
		.pop       (pop),
		.rdata     (head),
		.not_empty (not_empty),
		.full      (full)
	);

	lts_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (not_empty),
		.pop         (pop),
		.token_valid (token_valid),
		.token_data  (token_data),
		.token_stall (token_stall)
	);

endmodule

/* hdl/lts_front.sv */
// Front end: takes source bytes, classifies them and tags each with its offset.
module lts_front import lts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  byte_beat_t byte_data,
	input  logic       full,
	output logic       push,
	output entry_t     entry
);

	logic [OFFSET_BITS-1:0] pos_q;

	function automatic byte_class_t classify(input logic [7:0] b);
		byte_class_t c;
		c.act      = ACT_EMIT;
		c.op       = OP_EQUAL;
		c.kind     = K_UNKNOWN;
		c.is_digit = (b >= 8'("0")) && (b <= 8'("9"));
		c.is_word  = ((b >= 8'("a")) && (b <= 8'("z"))) ||
			((b >= 8'("A")) && (b <= 8'("Z"))) || (b == 8'("_"));
		case (b)
			8'("("):    c.kind = K_LEFT_PAREN;
			8'(")"):    c.kind = K_RIGHT_PAREN;
			8'("{"):    c.kind = K_LEFT_BRACE;
			8'("}"):    c.kind = K_RIGHT_BRACE;
			8'("*"):    c.kind = K_STAR;
			CH_DOT:     c.kind = K_DOT;
			8'(","):    c.kind = K_COMMA;
			8'(";"):    c.kind = K_SEMICOLON;
			8'("+"):    c.kind = K_PLUS;
			8'("-"):    c.kind = K_MINUS;
			8'(" "), 8'h09: c.kind = K_WHITESPACE;
			CH_NEWLINE: c.kind = K_NEWLINE;
			CH_EQUAL: begin
				c.act = ACT_OPER;
				c.op  = OP_EQUAL;
			end
			8'("!"): begin
				c.act = ACT_OPER;
				c.op  = OP_BANG;
			end
			8'(">"): begin
				c.act = ACT_OPER;
				c.op  = OP_GREATER;
			end
			8'("<"): begin
				c.act = ACT_OPER;
				c.op  = OP_LESS;
			end
			CH_SLASH: begin
				c.act = ACT_OPER;
				c.op  = OP_SLASH;
			end
			CH_QUOTE: c.act = ACT_STRING;
			default: begin
				if (c.is_digit)
					c.act = ACT_NUMBER;
				else if (c.is_word)
					c.act = ACT_WORD;
			end
		endcase
		return c;
	endfunction

	assign push = byte_valid && !full;

	always_comb begin
		entry.text_byte   = byte_data.text_byte;
		entry.end_of_text = byte_data.end_of_text;
		entry.pos         = pos_q;
		entry.cls         = classify(byte_data.text_byte);
	end

	// offset saturates; end of text restarts it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (byte_data.end_of_text)
				pos_q <= '0;
			else if (pos_q != {OFFSET_BITS{1'b1}})
				pos_q <= pos_q + 1'b1;
		end
	end

endmodule

/* hdl/lts_fifo.sv */
// Short queue of classified bytes between front and back end.
module lts_fifo import lts_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wdata,
	input  logic   pop,
	output entry_t rdata,
	output logic   not_empty,
	output logic   full
);

	entry_t                   mem_q [FIFO_DEPTH];
	logic [FIFO_IDX_BITS-1:0] wr_ptr_q;
	logic [FIFO_IDX_BITS-1:0] rd_ptr_q;
	logic [FIFO_IDX_BITS:0]   count_q;

	assign rdata     = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == (FIFO_IDX_BITS+1)'(FIFO_DEPTH));

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* hdl/lts_back.sv */
// Back end: scanner state machine and two-slot token output stage.
module lts_back import lts_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  entry_t head,
	input  logic   head_valid,
	output logic   pop,
	output logic   token_valid,
	output token_t token_data,
	input  logic   token_stall
);

	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_OPER    = 3'd1;
	localparam logic [2:0] MODE_COMMENT = 3'd2;
	localparam logic [2:0] MODE_STRING  = 3'd3;
	localparam logic [2:0] MODE_NUMBER  = 3'd4;
	localparam logic [2:0] MODE_WORD    = 3'd5;

	logic [2:0]             mode_q, mode_d;
	logic [2:0]             op_q, op_d;
	logic [KW_BITS-1:0]     prefix_q, prefix_d;
	logic                   long_q, long_d;
	logic                   dot_q, dot_d;
	logic [OFFSET_BITS-1:0] cts_q, cts_d;

	logic   out_valid_q, pend_valid_q;
	token_t out_q, pend_q;

	token_t                 res [2];
	logic [1:0]             n;
	logic                   rescan;
	logic [7:0]             b;
	logic [OFFSET_BITS-1:0] p;
	logic [OFFSET_BITS-1:0] flush_len;
	logic [KIND_BITS-1:0]   flush_kind;

	function automatic token_t mk(input logic [KIND_BITS-1:0] kind,
		input logic [OFFSET_BITS-1:0] start, input logic [OFFSET_BITS-1:0] len);
		token_t t;
		t.token_kind   = kind;
		t.token_start  = start;
		t.token_length = len;
		t.last_of_run  = 1'b0;
		return t;
	endfunction

	always_comb begin
		mode_d     = mode_q;
		op_d       = op_q;
		prefix_d   = prefix_q;
		long_d     = long_q;
		dot_d      = dot_q;
		cts_d      = cts_q;
		b          = head.text_byte;
		p          = head.pos;
		res[0]     = mk(K_UNKNOWN, p, tok_len(p, p, 1'b1));
		res[1]     = res[0];
		n          = 2'd0;
		rescan     = 1'b0;
		flush_len  = '0;
		flush_kind = K_UNKNOWN;

		case (mode_q)
			MODE_OPER: begin
				if (op_q == OP_SLASH) begin
					if (b == CH_SLASH) begin
						mode_d = MODE_COMMENT;
					end else begin
						res[n[0]] = mk(K_SLASH, cts_q, tok_len(cts_q, cts_q, 1'b1));
						n = n + 2'd1;
						rescan = 1'b1;
					end
				end else if (b == CH_EQUAL) begin
					res[n[0]] = mk(op_kind(op_q) + 1'b1, cts_q, tok_len(p, cts_q, 1'b1));
					n = n + 2'd1;
					mode_d = MODE_IDLE;
				end else begin
					res[n[0]] = mk(op_kind(op_q), cts_q, tok_len(cts_q, cts_q, 1'b1));
					n = n + 2'd1;
					rescan = 1'b1;
				end
			end
			MODE_COMMENT: begin
				if (b == CH_NEWLINE) begin
					res[0] = mk(K_COMMENT, cts_q, tok_len(p, cts_q, 1'b0));
					res[1] = mk(K_NEWLINE, p, tok_len(p, p, 1'b1));
					n = 2'd2;
					mode_d = MODE_IDLE;
				end
			end
			MODE_STRING: begin
				if (b == CH_QUOTE) begin
					res[n[0]] = mk(K_STRING, cts_q, tok_len(p, cts_q, 1'b1));
					n = n + 2'd1;
					mode_d = MODE_IDLE;
				end
			end
			MODE_NUMBER: begin
				if (b == CH_DOT) begin
					if (dot_q) begin
						res[n[0]] = mk(K_NUMBER_ERROR, cts_q, tok_len(p, cts_q, 1'b1));
						n = n + 2'd1;
						mode_d = MODE_IDLE;
					end else begin
						dot_d = 1'b1;
					end
				end else if (!head.cls.is_digit) begin
					res[n[0]] = mk(K_NUMBER, cts_q, tok_len(p, cts_q, 1'b0));
					n = n + 2'd1;
					rescan = 1'b1;
				end
			end
			MODE_WORD: begin
				if (head.cls.is_word || head.cls.is_digit) begin
					// prefix holds at most KEYWORD_MAX_CHARS bytes, all non-zero
					if ((prefix_q[KW_BITS-1 -: 8] == 8'd0) && !long_q)
						prefix_d = {prefix_q[KW_BITS-9:0], b};
					else
						long_d = 1'b1;
				end else begin
					res[n[0]] = mk(word_kind(prefix_q, long_q), cts_q,
						tok_len(p, cts_q, 1'b0));
					n = n + 2'd1;
					rescan = 1'b1;
				end
			end
			default: rescan = 1'b1;
		endcase

		if (rescan) begin
			mode_d = MODE_IDLE;
			cts_d  = p;
			case (head.cls.act)
				ACT_EMIT: begin
					res[n[0]] = mk(head.cls.kind, p, tok_len(p, p, 1'b1));
					n = n + 2'd1;
				end
				ACT_OPER: begin
					mode_d = MODE_OPER;
					op_d   = head.cls.op;
				end
				ACT_STRING: mode_d = MODE_STRING;
				ACT_NUMBER: begin
					mode_d = MODE_NUMBER;
					dot_d  = 1'b0;
				end
				ACT_WORD: begin
					mode_d   = MODE_WORD;
					prefix_d = KW_BITS'(b);
					long_d   = 1'b0;
				end
				default: ;
			endcase
		end

		// end of text: flush what is pending and start over
		if (head.end_of_text) begin
			flush_len = tok_len(p, cts_d, 1'b1);
			case (mode_d)
				MODE_OPER:    flush_kind = op_kind(op_d);
				MODE_COMMENT: flush_kind = K_COMMENT;
				MODE_STRING:  flush_kind = K_STRING_ERROR;
				MODE_NUMBER:  flush_kind = K_NUMBER;
				MODE_WORD:    flush_kind = word_kind(prefix_d, long_d);
				default:      flush_kind = K_UNKNOWN;
			endcase
			if (mode_d != MODE_IDLE) begin
				res[n[0]] = mk(flush_kind, cts_d, flush_len);
				n = n + 2'd1;
			end
			mode_d   = MODE_IDLE;
			op_d     = OP_EQUAL;
			prefix_d = '0;
			long_d   = 1'b0;
			dot_d    = 1'b0;
			cts_d    = '0;
		end

		res[0].last_of_run = (n == 2'd1);
		res[1].last_of_run = 1'b1;
	end

	// take a byte only when both output slots will be free
	assign pop = head_valid && !pend_valid_q && (!out_valid_q || !token_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			op_q         <= OP_EQUAL;
			prefix_q     <= '0;
			long_q       <= 1'b0;
			dot_q        <= 1'b0;
			cts_q        <= '0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q       <= mode_d;
				op_q         <= op_d;
				prefix_q     <= prefix_d;
				long_q       <= long_d;
				dot_q        <= dot_d;
				cts_q        <= cts_d;
				out_valid_q  <= (n != 2'd0);
				pend_valid_q <= (n == 2'd2);
			end else if (out_valid_q && !token_stall) begin
				out_valid_q  <= pend_valid_q;
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q  <= res[0];
			pend_q <= res[1];
		end else if (out_valid_q && !token_stall) begin
			out_q <= pend_q;
		end
	end

	assign token_valid = out_valid_q;
	assign token_data  = out_q;

	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("second token held without a first");

	a_pend_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> !out_q.last_of_run)
		else $error("first of two tokens marked last");

	a_pend_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_valid_q && !token_stall) |=> (out_valid_q && !pend_valid_q))
		else $error("held token not moved to output");

	a_eot_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.end_of_text) |=> (mode_q == MODE_IDLE && cts_q == '0))
		else $error("scanner not restarted after end of text");

endmodule
